/* hw/rtl/twd_pkg.sv */
// ----------------------------------------------------------------------------
// twd_pkg
// shared types and constants for the two-wire display frame writer
// ----------------------------------------------------------------------------
package twd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned BitCntW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] DelayTicksRst = 8'd1;
  localparam logic [ByteW-1:0] PollLimitRst = 8'd200;
  localparam logic [BitCntW-1:0] LastBit = 3'd7;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELAY_TICKS = 1'b0,
    CFG_POLL_LIMIT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START1 = 4'd1,
    PH_START2 = 4'd2,
    PH_BPRE   = 4'd3,
    PH_BSET   = 4'd4,
    PH_BHIGH  = 4'd5,
    PH_BLOW   = 4'd6,
    PH_AREL   = 4'd7,
    PH_ACLK   = 4'd8,
    PH_APOLL  = 4'd9,
    PH_ALOW   = 4'd10,
    PH_ADRV   = 4'd11,
    PH_STOP   = 4'd12
  } phase_e;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } lines_t;

  typedef struct packed {
    phase_e             phase;
    logic [BitCntW-1:0] bit_count;
    logic               byte_index;
    logic [ByteW-1:0]   shift_reg;
    logic [ByteW-1:0]   held_second;
    logic [ByteW-1:0]   delay_count;
    logic [ByteW-1:0]   poll_count;
    lines_t             lines;
    logic               timeout_seen;
  } seq_state_t;

  // one tick as captured from the input channel
  typedef struct packed {
    logic             op;
    logic [ByteW-1:0] first_byte;
    logic [ByteW-1:0] second_byte;
    logic             sda_in;
  } tick_t;

  typedef struct packed {
    logic scl;
    logic sda_out;
    logic sda_drive;
    logic busy_res;
    logic frame_done;
    logic ack_timeout;
  } result_t;

endpackage

/* hw/rtl/twd_intf.sv */
// ----------------------------------------------------------------------------
// twd channel interfaces
// valid/ready channels for ticks, results and register writes
// ----------------------------------------------------------------------------
interface twd_tick_if;
  import twd_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [ByteW-1:0] first_byte;
  logic [ByteW-1:0] second_byte;
  logic             sda_in;
  modport source (output valid, op, first_byte, second_byte, sda_in, input ready);
  modport sink (input valid, op, first_byte, second_byte, sda_in, output ready);
endinterface

interface twd_res_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda_out;
  logic sda_drive;
  logic busy_res;
  logic frame_done;
  logic ack_timeout;
  modport source (output valid, scl, sda_out, sda_drive, busy_res, frame_done, ack_timeout,
                  input ready);
  modport sink (input valid, scl, sda_out, sda_drive, busy_res, frame_done, ack_timeout,
                output ready);
endinterface

interface twd_cfg_if;
  import twd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/two_wire_display_frame_writer_core.sv */
// ----------------------------------------------------------------------------
// two_wire_display_frame_writer_core
// tick-driven two-byte write master for a two-wire led-driver bus
// ----------------------------------------------------------------------------
// usage:
//   in_i   : one request per bus tick (op, first_byte, second_byte, sda_in);
//            op high while idle latches both bytes and starts a frame
//   res_o  : one result per tick with the line levels after that tick,
//            busy, the frame-done pulse and the sticky acknowledge timeout
//   cfg_i  : register writes (delay_ticks, ack_poll_limit), always ready;
//            write only while no tick is in flight
// latency: result valid one cycle after the accepting edge of its tick (input
//   register, then sequencer logic into the result register)
// throughput: one tick per cycle; both stages advance together whenever the
//   result register is empty or being drained
// stall: when res_o.ready is low the result and the captured tick hold and
//   in_i.ready drops once both stages are full; no tick is lost
// reset: sequencer idle, lines high and driven, timeout cleared, delay unit 1
//   tick, poll limit 200, both stages empty
// ----------------------------------------------------------------------------
module two_wire_display_frame_writer_core
  import twd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  twd_tick_if.sink in_i,
  twd_res_if.source res_o,
  twd_cfg_if.sink  cfg_i
);

  // configuration registers
  logic [ByteW-1:0] delay_ticks_q;
  logic [ByteW-1:0] poll_limit_q;

  // captured tick
  logic  tick_vld_q;
  tick_t tick_q;

  // sequencer state and result register
  seq_state_t seq_q;
  seq_state_t seq_d;
  result_t    res_d;
  result_t    res_q;
  logic       res_vld_q;

  logic res_free;
  logic tick_go;
  logic in_req;

  // result register drains or is empty: the captured tick may move on
  assign res_free = !res_vld_q || res_o.ready;
  assign tick_go  = tick_vld_q && res_free;
  assign in_i.ready = !tick_vld_q || tick_go;
  assign in_req   = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ticks_q <= DelayTicksRst;
      poll_limit_q  <= PollLimitRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_DELAY_TICKS: delay_ticks_q <= cfg_i.data;
        CFG_POLL_LIMIT:  poll_limit_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      tick_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      tick_q <= '{op:          in_i.op,
                  first_byte:  in_i.first_byte,
                  second_byte: in_i.second_byte,
                  sda_in:      in_i.sda_in};
    end
  end

  twd_step u_step (
    .cur_i         (seq_q),
    .tick_i        (tick_q),
    .delay_ticks_i (delay_ticks_q),
    .poll_limit_i  (poll_limit_q),
    .nxt_o         (seq_d),
    .res_o         (res_d)
  );

  // sequencer state advances once per tick that reaches the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '{phase:        PH_IDLE,
                 bit_count:    '0,
                 byte_index:   1'b0,
                 shift_reg:    '0,
                 held_second:  '0,
                 delay_count:  '0,
                 poll_count:   '0,
                 lines:        '{scl: 1'b1, sda: 1'b1, drv: 1'b1},
                 timeout_seen: 1'b0};
    end else if (tick_go) begin
      seq_q <= seq_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= tick_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.scl         = res_q.scl;
  assign res_o.sda_out     = res_q.sda_out;
  assign res_o.sda_drive   = res_q.sda_drive;
  assign res_o.busy_res    = res_q.busy_res;
  assign res_o.frame_done  = res_q.frame_done;
  assign res_o.ack_timeout = res_q.ack_timeout;

endmodule

/* hw/rtl/twd_step.sv */
// ----------------------------------------------------------------------------
// twd_step
// next-state and line levels of the bus sequencer for one tick
// ----------------------------------------------------------------------------
module twd_step
  import twd_pkg::*;
(
  input  seq_state_t       cur_i,
  input  tick_t            tick_i,
  input  logic [ByteW-1:0] delay_ticks_i,
  input  logic [ByteW-1:0] poll_limit_i,
  output seq_state_t       nxt_o,
  output result_t          res_o
);

  logic [ByteW-1:0] unit;
  logic [ByteW-1:0] limit;
  logic [ByteW-1:0] dc_inc;
  logic [ByteW-1:0] poll_inc;
  logic [ByteW-1:0] shifted;
  logic             done;

  assign unit     = (delay_ticks_i == '0) ? ByteW'(1) : delay_ticks_i;
  assign limit    = (poll_limit_i == '0) ? ByteW'(1) : poll_limit_i;
  assign dc_inc   = cur_i.delay_count + ByteW'(1);
  assign poll_inc = cur_i.poll_count + ByteW'(1);
  assign shifted  = {cur_i.shift_reg[ByteW-2:0], 1'b0};

  always_comb begin
    nxt_o = cur_i;
    done  = 1'b0;
    unique case (cur_i.phase)
      PH_IDLE: begin
        if (tick_i.op) begin
          nxt_o.shift_reg    = tick_i.first_byte;
          nxt_o.held_second  = tick_i.second_byte;
          nxt_o.bit_count    = '0;
          nxt_o.byte_index   = 1'b0;
          nxt_o.poll_count   = '0;
          nxt_o.timeout_seen = 1'b0;
          nxt_o.phase        = PH_START1;
          nxt_o.lines        = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
          nxt_o.delay_count  = '0;
        end
      end
      PH_APOLL: begin
        if (!tick_i.sda_in) begin
          nxt_o.phase       = PH_ALOW;
          nxt_o.lines       = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
          nxt_o.delay_count = '0;
        end else begin
          nxt_o.poll_count = poll_inc;
          if (poll_inc >= limit) begin
            nxt_o.timeout_seen = 1'b1;
            nxt_o.phase        = PH_ALOW;
            nxt_o.lines        = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
            nxt_o.delay_count  = '0;
          end
        end
      end
      default: begin
        // timed phases: move on once the delay unit has run out
        nxt_o.delay_count = dc_inc;
        if (dc_inc >= unit) begin
          nxt_o.delay_count = '0;
          unique case (cur_i.phase)
            PH_START1: begin
              nxt_o.phase = PH_START2;
              nxt_o.lines = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
            end
            PH_START2: begin
              nxt_o.phase = PH_BPRE;
              nxt_o.lines = '{scl: 1'b0, sda: cur_i.lines.sda, drv: 1'b1};
            end
            PH_BPRE: begin
              nxt_o.phase = PH_BSET;
              nxt_o.lines = '{scl: 1'b0, sda: cur_i.shift_reg[ByteW-1], drv: 1'b1};
            end
            PH_BSET: begin
              nxt_o.phase = PH_BHIGH;
              nxt_o.lines = '{scl: 1'b1, sda: cur_i.lines.sda, drv: 1'b1};
            end
            PH_BHIGH: begin
              nxt_o.phase = PH_BLOW;
              nxt_o.lines = '{scl: 1'b0, sda: cur_i.lines.sda, drv: 1'b1};
            end
            PH_BLOW: begin
              nxt_o.shift_reg = shifted;
              if (cur_i.bit_count == LastBit) begin
                nxt_o.bit_count = '0;
                nxt_o.phase     = PH_AREL;
                nxt_o.lines     = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
              end else begin
                nxt_o.bit_count = cur_i.bit_count + BitCntW'(1);
                nxt_o.phase     = PH_BSET;
                nxt_o.lines     = '{scl: 1'b0, sda: shifted[ByteW-1], drv: 1'b1};
              end
            end
            PH_AREL: begin
              nxt_o.phase = PH_ACLK;
              nxt_o.lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
            end
            PH_ACLK: begin
              nxt_o.phase      = PH_APOLL;
              nxt_o.lines      = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
              nxt_o.poll_count = '0;
            end
            PH_ALOW: begin
              nxt_o.phase = PH_ADRV;
              nxt_o.lines = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
            end
            PH_ADRV: begin
              if (!cur_i.byte_index) begin
                nxt_o.byte_index = 1'b1;
                nxt_o.shift_reg  = cur_i.held_second;
                nxt_o.bit_count  = '0;
                nxt_o.phase      = PH_BPRE;
                nxt_o.lines      = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
              end else begin
                nxt_o.phase = PH_STOP;
                nxt_o.lines = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
              end
            end
            PH_STOP: begin
              nxt_o.phase      = PH_IDLE;
              nxt_o.lines      = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
              nxt_o.byte_index = 1'b0;
              done             = 1'b1;
            end
            default: begin
              nxt_o.phase = PH_IDLE;
              nxt_o.lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            end
          endcase
        end
      end
    endcase
  end

  assign res_o = '{scl:         nxt_o.lines.scl,
                   sda_out:     nxt_o.lines.sda,
                   sda_drive:   nxt_o.lines.drv,
                   busy_res:    (nxt_o.phase != PH_IDLE),
                   frame_done:  done,
                   ack_timeout: nxt_o.timeout_seen};

endmodule
